/* sv/sha1s_pkg.sv */
// ----------------------------------------------------------------------------
// sha1s_pkg
// Types, sizes and constants shared by the SHA-1 stream hasher files.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    typedef logic [31:0] word_t;

    // one input beat: a message byte with its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } in_beat_t;

    // one output beat: a digest word with its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    localparam int BLOCK_WORDS  = 16;
    localparam int WORD_AW      = $clog2(BLOCK_WORDS);
    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // word slots of the 64-bit length field
    localparam logic [WORD_AW-1:0] LEN_HI_SLOT = 4'd14;
    localparam logic [WORD_AW-1:0] LEN_LO_SLOT = 4'd15;

    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;

    function automatic word_t iv_word(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hefcdab89;
            3'd2:    v = 32'h98badcfe;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hc3d2e1f0;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* sv/sha1_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream; emits the 160-bit digest as five 32-bit beats.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while a block fills; every 64th byte
//   triggers a compression (load, 80 rounds, chain add) run by the single
//   round unit, during which no byte beat is taken.
// After a last beat: the pad word, zero-fill at one word a cycle (up to 13
//   words, 15 when the length spills into a second block), 2 length writes,
//   then one or two compressions (one more first if that beat fills the
//   block), then the five digest beats, one per cycle when the sink is ready.
// Reset (rst_n low, asynchronous): chaining words to the SHA-1 IV, bit count
//   and fill to zero, no digest beat pending. The block RAM is not cleared.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_beat_t  byte_beat,
    output logic      digest_valid,
    input  logic      digest_ready,
    output out_beat_t digest_beat
);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;   // taking byte beats
    localparam logic [3:0] ST_PADW  = 4'd1;   // write the word holding 0x80
    localparam logic [3:0] ST_ZERO  = 4'd2;   // zero-fill words
    localparam logic [3:0] ST_LENH  = 4'd3;   // length, upper word
    localparam logic [3:0] ST_LENL  = 4'd4;   // length, lower word
    localparam logic [3:0] ST_CLOAD = 4'd5;   // fetch word 0, load a..e
    localparam logic [3:0] ST_ROUND = 4'd6;   // one SHA-1 round per cycle
    localparam logic [3:0] ST_CADD  = 4'd7;   // fold a..e into chain
    localparam logic [3:0] ST_OUT   = 4'd8;   // stream the digest

    // where to go once a compression is done
    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_ZERO = 2'd2;
    localparam logic [1:0] RET_OUT  = 2'd3;

    localparam logic [WORD_AW:0] ZERO_END     = 5'd14;   // length follows
    localparam logic [WORD_AW:0] ZERO_END_OVF = 5'd16;   // whole block, then again
    localparam logic [6:0]       LAST_ROUND   = 7'(ROUNDS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]       state_reg, state_next;
    logic [1:0]       ret_reg, ret_next;
    logic [5:0]       fill_reg, fill_next;        // bytes in the current block
    logic [63:0]      count_reg, count_next;      // message length in bits
    logic [WORD_AW:0] wptr_reg, wptr_next;        // padding write pointer
    logic             ovf_reg, ovf_next;          // padding spills to a second block
    logic [6:0]       rnd_reg, rnd_next;
    logic [2:0]       oidx_reg, oidx_next;
    logic             ovalid_reg, ovalid_next;
    out_beat_t        obeat_reg, obeat_next;
    logic [23:0]      acc_reg, acc_next;          // bytes of the word in progress
    word_t            a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t            a_next, b_next, c_next, d_next, e_next;
    word_t            h_reg [DIGEST_WORDS];
    word_t            h_next [DIGEST_WORDS];
    word_t            sched_reg [BLOCK_WORDS];    // last 16 schedule words, [15] newest
    word_t            sched_next [BLOCK_WORDS];

    // ------------------------------------------------------------------
    // Message block RAM, 16 x 32. Writes only happen outside compression
    // and the block word a round needs was written before the compression
    // began, so read and write never meet on one entry.
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [WORD_AW-1:0] ram_waddr, ram_raddr;
    word_t              ram_wdata, ram_rdata;

    sha1s_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Round datapath
    // ------------------------------------------------------------------
    word_t rnd_w, rnd_f, rnd_k, rnd_t, sched_mix;
    word_t pad_word;

    always_comb
    begin
        sched_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        if (rnd_reg < 7'd16)
        begin
            rnd_w = ram_rdata;
        end
        else
        begin
            rnd_w = {sched_mix[30:0], sched_mix[31]};
        end

        if (rnd_reg < 7'd20)
        begin
            rnd_f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            rnd_k = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            rnd_f = b_reg ^ c_reg ^ d_reg;
            rnd_k = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            rnd_f = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            rnd_k = K2;
        end
        else
        begin
            rnd_f = b_reg ^ c_reg ^ d_reg;
            rnd_k = K3;
        end

        rnd_t = {a_reg[26:0], a_reg[31:27]} + rnd_f + e_reg + rnd_k + rnd_w;
    end

    // word that carries the 0x80 marker behind any bytes already buffered
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h000000};
            2'd1:    pad_word = {acc_reg[7:0], PAD_BYTE, 16'h0000};
            2'd2:    pad_word = {acc_reg[15:0], PAD_BYTE, 8'h00};
            2'd3:    pad_word = {acc_reg[23:0], PAD_BYTE};
            default: pad_word = {PAD_BYTE, 24'h000000};
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic byte_take, out_free;

    assign byte_ready = (state_reg == ST_IDLE);
    assign byte_take  = byte_valid && byte_ready;
    assign out_free   = !ovalid_reg || digest_ready;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        wptr_next   = wptr_reg;
        ovf_next    = ovf_reg;
        rnd_next    = rnd_reg;
        oidx_next   = oidx_reg;
        acc_next    = acc_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        obeat_next  = obeat_reg;
        ovalid_next = ovalid_reg && !digest_ready;
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            h_next[i] = h_reg[i];
        end
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            sched_next[i] = sched_reg[i];
        end
        ram_we    = 1'b0;
        ram_waddr = fill_reg[5:2];
        ram_wdata = pad_word;
        ram_raddr = rnd_reg[WORD_AW-1:0] + 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (byte_take)
                begin
                    if (byte_beat.byte_present)
                    begin
                        fill_next  = fill_reg + 1'b1;
                        count_next = count_reg + 64'd8;
                        acc_next   = {acc_reg[15:0], byte_beat.data_byte};
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = fill_reg[5:2];
                            ram_wdata = {acc_reg, byte_beat.data_byte};
                        end
                    end
                    if (byte_beat.byte_present && (fill_reg == 6'd63))
                    begin
                        // block full: compress first, pad afterwards if last
                        state_next = ST_CLOAD;
                        ret_next   = byte_beat.last_byte ? RET_PAD : RET_IDLE;
                    end
                    else if (byte_beat.last_byte)
                    begin
                        state_next = ST_PADW;
                    end
                end
            end

            ST_PADW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fill_reg[5:2];
                ram_wdata  = pad_word;
                wptr_next  = {1'b0, fill_reg[5:2]} + 1'b1;
                ovf_next   = (fill_reg[5:2] >= LEN_HI_SLOT);
                state_next = ST_ZERO;
            end

            ST_ZERO:
            begin
                if (wptr_reg == (ovf_reg ? ZERO_END_OVF : ZERO_END))
                begin
                    if (ovf_reg)
                    begin
                        // no room for the length: finish this block, then a fresh one
                        state_next = ST_CLOAD;
                        ret_next   = RET_ZERO;
                        wptr_next  = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_LENH;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wptr_reg[WORD_AW-1:0];
                    ram_wdata = '0;
                    wptr_next = wptr_reg + 1'b1;
                end
            end

            ST_LENH:
            begin
                ram_we     = 1'b1;
                ram_waddr  = LEN_HI_SLOT;
                ram_wdata  = count_reg[63:32];
                state_next = ST_LENL;
            end

            ST_LENL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = LEN_LO_SLOT;
                ram_wdata  = count_reg[31:0];
                state_next = ST_CLOAD;
                ret_next   = RET_OUT;
            end

            ST_CLOAD:
            begin
                ram_raddr  = '0;
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                e_next     = h_reg[4];
                rnd_next   = '0;
                state_next = ST_ROUND;
            end

            ST_ROUND:
            begin
                e_next = d_reg;
                d_next = c_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                b_next = a_reg;
                a_next = rnd_t;
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    sched_next[i] = sched_reg[i + 1];
                end
                sched_next[BLOCK_WORDS - 1] = rnd_w;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_CADD;
                end
            end

            ST_CADD:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                case (ret_reg)
                    RET_IDLE: state_next = ST_IDLE;
                    RET_PAD:  state_next = ST_PADW;
                    RET_ZERO: state_next = ST_ZERO;
                    RET_OUT:
                    begin
                        state_next = ST_OUT;
                        oidx_next  = '0;
                    end
                    default:  state_next = ST_IDLE;
                endcase
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next            = 1'b1;
                    obeat_next.digest_word = h_reg[oidx_reg];
                    obeat_next.word_index  = oidx_reg;
                    obeat_next.last_word   = (oidx_reg == 3'(DIGEST_WORDS - 1));
                    oidx_next              = oidx_reg + 1'b1;
                    if (oidx_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        // final word staged: back to the initial state
                        for (int i = 0; i < DIGEST_WORDS; i++)
                        begin
                            h_next[i] = iv_word(3'(i));
                        end
                        count_next = '0;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ret_reg    <= RET_IDLE;
            fill_reg   <= '0;
            count_reg  <= '0;
            wptr_reg   <= '0;
            ovf_reg    <= 1'b0;
            rnd_reg    <= '0;
            oidx_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            wptr_reg   <= wptr_next;
            ovf_reg    <= ovf_next;
            rnd_reg    <= rnd_next;
            oidx_reg   <= oidx_next;
            ovalid_reg <= ovalid_next;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    // payload: working variables, schedule, partial word, output beat
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        obeat_reg <= obeat_next;
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            sched_reg[i] <= sched_next[i];
        end
    end

    assign digest_valid = ovalid_reg;
    assign digest_beat  = obeat_reg;

endmodule

/* sv/sha1s_ram.sv */
// ----------------------------------------------------------------------------
// sha1s_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sha1s_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sha1s_checker.sv */
// ----------------------------------------------------------------------------
// sha1s_checker
// Port-level assertions for the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1s_checker
    import sha1s_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_ready,
    input in_beat_t  byte_beat,
    input logic      digest_valid,
    input logic      digest_ready,
    input out_beat_t digest_beat
);

    // a stalled byte beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(byte_beat))
        else $error("byte beat changed while stalled");

    // a stalled digest beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest_beat))
        else $error("digest beat changed while stalled");

    // last flag marks exactly the fifth word
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest_beat.last_word == (digest_beat.word_index == 3'd4)))
        else $error("last_word does not match word_index");

    // words follow in order within one digest
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest_beat.last_word |=>
            !digest_valid || (digest_beat.word_index == $past(digest_beat.word_index) + 3'd1))
        else $error("digest words out of order");

    // bytes are only taken while no digest is under way, bar its final word
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ready && digest_valid |-> digest_beat.last_word)
        else $error("byte beat accepted during digest output");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (.*);
